[rtl/bble_pkg.sv]
// ----------------------------------------------------------------------------
// bble_pkg
// Shared types and constants for the bounded byte list engine: command and
// result beats, operation and status codes, and the per-cell control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bble_pkg;

  localparam int DEPTH_DEF = 16;

  typedef enum logic [3:0] {
    ACT_INSERT_AT      = 4'd0,
    ACT_PUSH_FRONT     = 4'd1,
    ACT_PUSH_BACK      = 4'd2,
    ACT_INSERT_ORDERED = 4'd3,
    ACT_REMOVE_AT      = 4'd4,
    ACT_POP_FRONT      = 4'd5,
    ACT_POP_BACK       = 4'd6,
    ACT_REPLACE        = 4'd7,
    ACT_READ_AT        = 4'd8,
    ACT_FIRST          = 4'd9,
    ACT_LAST           = 4'd10,
    ACT_CLEAR          = 4'd11
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0]        action;
    logic [4:0]        position;
    logic signed [7:0] value;
  } list_in_t;

  typedef struct packed {
    logic signed [7:0] read_value;
    logic [4:0]        item_count;
    logic [1:0]        status;
  } list_out_t;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  // Compare results that a cell reports for the ordered insert.
  typedef struct packed {
    logic above_left;    // value > entry of the lower neighbor
    logic at_most_self;  // value <= own entry
    logic below_self;    // value < own entry
  } cell_flags_t;

endpackage

`default_nettype wire

[rtl/bble_cell.sv]
// ----------------------------------------------------------------------------
// bble_cell
// One list slot: holds a byte, shifts it to or from its neighbors, and
// compares the incoming value against its own entry and its lower neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bble_cell
  import bble_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_op_t          op,
  input  wire logic signed [7:0] value,
  input  wire logic signed [7:0] left,
  input  wire logic signed [7:0] right,
  output logic signed [7:0]      entry,
  output cell_flags_t            flags
);

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:       entry <= value;
      CELL_FROM_LEFT:  entry <= left;
      CELL_FROM_RIGHT: entry <= right;
      default:         entry <= entry;
    endcase
  end

  always_comb begin
    flags.above_left   = value > left;
    flags.at_most_self = value <= entry;
    flags.below_self   = value < entry;
  end

endmodule

`default_nettype wire

[rtl/bble_first.sv]
// ----------------------------------------------------------------------------
// bble_first
// Turns a vector of candidate slots into a mask of every slot at or above
// the lowest candidate, using one two's-complement add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bble_first
  import bble_pkg::*;
#(
  parameter int W = DEPTH_DEF
) (
  input  wire logic [W-1:0] hot,
  output logic [W-1:0]      mask
);

  // x | -x keeps the lowest set bit and fills every bit above it.
  assign mask = hot | (~hot + W'(1));

endmodule

`default_nettype wire

[rtl/bounded_byte_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// bounded_byte_list_engine_unit
// Ordered list of up to DEPTH signed bytes held in a row of cells; inserts
// shift the upper cells up and removals shift them down.
// ----------------------------------------------------------------------------
// The result beat appears on the cycle after the command is taken.
// One command is taken per cycle while busy is low; every cell shifts or
// compares in parallel and the slot search is a single carry chain across the row.
// Reset clears the count and the result strobe; busy is set while reset is
// held and cleared once reset is released. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module bounded_byte_list_engine_unit
  import bble_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire list_in_t  cmd,
  output logic           done,
  output list_out_t      result
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > 5) ? CW : 5;

  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_next;
  logic               accept;
  logic [CMPW-1:0]    pos_w;
  logic [CMPW-1:0]    cnt_w;
  logic               full;
  logic               empty;
  status_t            st;
  logic               do_ins;
  logic               do_rem;
  logic               do_rep;
  logic               do_rd;
  logic [IW-1:0]      rd_idx;
  logic [DEPTH-1:0]   hot;
  logic [DEPTH-1:0]   ge_mask;
  logic [DEPTH-1:0]   ge_prev;
  logic signed [7:0]  ent [DEPTH];
  cell_flags_t        flags [DEPTH];
  cell_op_t           cell_op [DEPTH];

  assign accept = start && !busy;
  assign pos_w  = CMPW'(cmd.position);
  assign cnt_w  = CMPW'(cnt);
  assign full   = (cnt == CW'(DEPTH));
  assign empty  = (cnt == '0);

  // Operation decode, status, slot select, read index and next count.
  always_comb begin
    st       = ST_OK;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_rep   = 1'b0;
    do_rd    = 1'b0;
    rd_idx   = '0;
    cnt_next = cnt;
    hot      = '0;
    case (action_t'(cmd.action))
      ACT_INSERT_AT: begin
        if (pos_w > cnt_w) st = ST_RANGE;
        else if (full) st = ST_FULL;
        else do_ins = 1'b1;
        for (int i = 0; i < DEPTH; i++) hot[i] = (CMPW'(i) == pos_w);
      end
      ACT_PUSH_FRONT: begin
        if (full) st = ST_FULL;
        else do_ins = 1'b1;
        hot[0] = 1'b1;
      end
      ACT_PUSH_BACK: begin
        if (full) st = ST_FULL;
        else do_ins = 1'b1;
        for (int i = 0; i < DEPTH; i++) hot[i] = (CW'(i) == cnt);
      end
      ACT_INSERT_ORDERED: begin
        if (full) st = ST_FULL;
        else do_ins = 1'b1;
        // A slot qualifies where the value fits between its neighbors; the
        // back of the list always qualifies, and the lowest one wins.
        hot[0] = empty || flags[0].below_self;
        for (int i = 1; i < DEPTH; i++) begin
          hot[i] = ((CW'(i) < cnt) && flags[i].above_left && flags[i].at_most_self) ||
                   (CW'(i) == cnt);
        end
      end
      ACT_REMOVE_AT: begin
        if (pos_w >= cnt_w) st = ST_RANGE;
        else do_rem = 1'b1;
        for (int i = 0; i < DEPTH; i++) hot[i] = (CMPW'(i) == pos_w);
      end
      ACT_POP_FRONT: begin
        if (empty) st = ST_EMPTY;
        else do_rem = 1'b1;
        hot[0] = 1'b1;
      end
      ACT_POP_BACK: begin
        if (empty) st = ST_EMPTY;
        else do_rem = 1'b1;
        for (int i = 0; i < DEPTH; i++) hot[i] = (CW'(i) == cnt - CW'(1));
      end
      ACT_REPLACE: begin
        if (pos_w >= cnt_w) st = ST_RANGE;
        else do_rep = 1'b1;
        for (int i = 0; i < DEPTH; i++) hot[i] = (CMPW'(i) == pos_w);
      end
      ACT_READ_AT: begin
        if (pos_w >= cnt_w) st = ST_RANGE;
        else do_rd = 1'b1;
        rd_idx = IW'(pos_w);
      end
      ACT_FIRST: begin
        if (empty) st = ST_EMPTY;
        else do_rd = 1'b1;
        rd_idx = '0;
      end
      ACT_LAST: begin
        if (empty) st = ST_EMPTY;
        else do_rd = 1'b1;
        rd_idx = IW'(cnt - CW'(1));
      end
      ACT_CLEAR: cnt_next = '0;
      default: ;
    endcase
    if (do_ins) cnt_next = cnt + CW'(1);
    if (do_rem) cnt_next = cnt - CW'(1);
  end

  bble_first #(
    .W(DEPTH)
  ) u_first (
    .hot  (hot),
    .mask (ge_mask)
  );

  assign ge_prev = {ge_mask[DEPTH-2:0], 1'b0};

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (accept) begin
        if (do_ins) begin
          if (ge_prev[i]) cell_op[i] = CELL_FROM_LEFT;
          else if (ge_mask[i]) cell_op[i] = CELL_LOAD;
        end else if (do_rem) begin
          if (ge_mask[i]) cell_op[i] = CELL_FROM_RIGHT;
        end else if (do_rep) begin
          if (hot[i]) cell_op[i] = CELL_LOAD;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [7:0] left_in;
    logic signed [7:0] right_in;
    if (g == 0) begin : g_lo
      assign left_in = 8'sd0;
    end else begin : g_mid_lo
      assign left_in = ent[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign right_in = 8'sd0;
    end else begin : g_mid_hi
      assign right_in = ent[g+1];
    end
    bble_cell u_cell (
      .clk   (clk),
      .op    (cell_op[g]),
      .value (cmd.value),
      .left  (left_in),
      .right (right_in),
      .entry (ent[g]),
      .flags (flags[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      done <= accept;
      if (accept) begin
        cnt               <= cnt_next;
        result.read_value <= do_rd ? ent[rd_idx] : 8'sd0;
        result.item_count <= 5'(cnt_next);
        result.status     <= st;
      end
    end
  end

  // The strobe only follows a taken command.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(start && !busy))
    else $error("result beat without a command beat");

  // The count never passes the list depth.
  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("count exceeds depth");

  // A failed command leaves the count untouched.
  assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> $stable(cnt))
    else $error("count changed on a failed command");

  // A failed command reads nothing.
  assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.read_value == 8'sd0))
    else $error("read value on a failed command");

  // The reported count matches the list held.
  assert property (@(posedge clk) disable iff (rst) done |-> (result.item_count == 5'(cnt)))
    else $error("reported count disagrees with list");

endmodule

`default_nettype wire
